>>> rtl/core/sali_pkg.sv
package sali_pkg;

  localparam int VAL_W        = 32;
  localparam int CNT_W        = 5;
  localparam int CAPACITY_DEF = 16;
  localparam logic [CNT_W-1:0] LIMIT_RST = 5'd16;

  typedef enum logic [1:0] {
    KIND_SORTED = 2'd0,
    KIND_POS    = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2,
    ST_BAD  = 2'd3
  } status_t;

  typedef struct packed {
    logic             sorted;
    logic             rd;
    logic [VAL_W-1:0] val;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

endpackage

>>> rtl/core/sali_cell.sv
module sali_cell
  import sali_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic             shift_en,
  input  logic [VAL_W-1:0] left_data,
  input  logic             left_ge,
  output logic [VAL_W-1:0] data,
  output logic             ge,
  output logic             hit,
  output logic [VAL_W-1:0] rd_data
);

  localparam int IW = (CNT_W > $clog2(IDX + 2)) ? CNT_W : $clog2(IDX + 2);

  logic [VAL_W-1:0] entry_r;
  logic [VAL_W-1:0] entry_nxt;
  logic             in_use;
  logic             lt;
  logic             self_ge;

  assign in_use  = IW'(IDX) < IW'(ctl.count);
  assign lt      = in_use && ($signed(entry_r) < $signed(ctl.val));
  assign self_ge = ctl.sorted ? !lt : (IW'(IDX + 1) >= IW'(ctl.pos));
  assign ge      = self_ge || left_ge;
  assign hit     = in_use && ge && !left_ge && (entry_r == ctl.val);
  assign rd_data = (ctl.rd && (IW'(IDX) == IW'(ctl.pos))) ? entry_r : '0;
  assign data    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (shift_en && ge) begin
      entry_nxt = left_ge ? left_data : ctl.val;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> rtl/core/sorted_array_list_insert.sv
// Channel | Dir | tdata (low bit up)                    | tuser
// in_     | in  | value[31:0], position[36:32], pad     | kind[1:0]
// out_    | out | entry_count[4:0], read_value[36:5], pad| status[1:0]
// cfg_    | in  | capacity_limit[4:0]                   | -
// For each request every cell compares and shifts at once; the result
// lands in the output register on the accepting edge.
// A new request is taken each cycle while the output register is empty or being drained.
// Reset clears the entry count, the output valid and sets the limit to 16; entries stay
// undefined until written.
// A stalled output holds its request and blocks input until taken.
module sorted_array_list_insert
  import sali_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], position[36:32], zero pad
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // entry_count[4:0], read_value[36:5], zero pad
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  localparam int LW = (CNT_W > $clog2(CAPACITY + 1)) ? CNT_W : $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] limit_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic [CNT_W-1:0] out_count_r;
  logic [VAL_W-1:0] rd_r, rd_nxt;

  kind_t            kind;
  logic [VAL_W-1:0] in_val;
  logic [CNT_W-1:0] in_pos;
  logic             accept;
  logic             is_ins, full, bad_pos, dup, shift_en;
  logic [LW-1:0]    eff_limit;
  cell_ctl_t        ctl;

  logic [VAL_W-1:0] c_data [CAPACITY];
  logic             c_ge   [CAPACITY];
  logic [CAPACITY-1:0] c_hit;
  logic [VAL_W-1:0] c_rd   [CAPACITY];

  assign kind   = kind_t'(in_tuser);
  assign in_val = in_tdata[31:0];
  assign in_pos = in_tdata[36:32];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign eff_limit = (LW'(limit_r) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(limit_r);
  assign is_ins    = (kind == KIND_SORTED) || (kind == KIND_POS);
  assign full      = LW'(count_r) >= eff_limit;
  assign bad_pos   = (in_pos == '0) || ({1'b0, in_pos} > ({1'b0, count_r} + 6'd1));
  assign dup       = |c_hit;

  assign ctl.sorted = (kind == KIND_SORTED);
  assign ctl.rd     = (kind == KIND_READ);
  assign ctl.val    = in_val;
  assign ctl.pos    = in_pos;
  assign ctl.count  = count_r;

  assign shift_en = accept && is_ins && !full &&
                    (ctl.sorted ? !dup : !bad_pos);

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
        sali_cell #(.IDX(g)) u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .shift_en (shift_en),
          .left_data(in_val),
          .left_ge  (1'b0),
          .data     (c_data[g]),
          .ge       (c_ge[g]),
          .hit      (c_hit[g]),
          .rd_data  (c_rd[g])
        );
      end else begin : g_body
        sali_cell #(.IDX(g)) u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .shift_en (shift_en),
          .left_data(c_data[g-1]),
          .left_ge  (c_ge[g-1]),
          .data     (c_data[g]),
          .ge       (c_ge[g]),
          .hit      (c_hit[g]),
          .rd_data  (c_rd[g])
        );
      end
    end
  endgenerate

  always_comb begin
    status_nxt = ST_OK;
    count_nxt  = count_r;
    rd_nxt     = '0;
    case (kind)
      KIND_SORTED: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (dup) begin
          status_nxt = ST_DUP;
        end else begin
          count_nxt = count_r + 5'd1;
        end
      end
      KIND_POS: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (bad_pos) begin
          status_nxt = ST_BAD;
        end else begin
          count_nxt = count_r + 5'd1;
        end
      end
      KIND_READ: begin
        if (in_pos < count_r) begin
          for (int i = 0; i < CAPACITY; i++) begin
            rd_nxt = rd_nxt | c_rd[i];
          end
        end else begin
          status_nxt = ST_BAD;
        end
      end
      KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RST;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      out_count_r <= count_nxt;
      rd_r        <= rd_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'b000, rd_r, out_count_r};

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(count_r) <= LW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (kind != KIND_CLEAR) |=>
      (count_r == $past(count_r)) || (count_r == $past(count_r) + 5'd1))
    else $error("entry count moved by more than one");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (kind == KIND_CLEAR) |=> (count_r == '0) && (out_tdata[4:0] == '0))
    else $error("clear did not empty the list");

  a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (status_nxt != ST_OK) |=> (count_r == $past(count_r)))
    else $error("rejected request changed the count");

  a_result_match: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid && (out_tdata[4:0] == count_r))
    else $error("reported count differs from held count");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import sali_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 150;

  typedef struct {
    status_t          status;
    logic [CNT_W-1:0] entry_count;
    logic [VAL_W-1:0] read_value;
  } list_outcome_t;

  class list_tracker;
    logic [VAL_W-1:0] entries [CAPACITY];
    int unsigned      count;
    logic [CNT_W-1:0] limit;
    list_outcome_t    pending[$];
    int               errors;

    function new();
      count  = 0;
      limit  = LIMIT_RST;
      errors = 0;
      foreach (entries[i]) entries[i] = '0;
    endfunction

    function void set_limit(logic [CNT_W-1:0] v);
      limit = v;
    endfunction

    function void place_at(int unsigned p, logic [VAL_W-1:0] v);
      for (int unsigned i = count; i > p; i--) entries[i] = entries[i-1];
      entries[p] = v;
      count++;
    endfunction

    function void note_request(kind_t k, logic [VAL_W-1:0] v, logic [CNT_W-1:0] p);
      list_outcome_t o;
      int unsigned   lim;
      int unsigned   slot;
      o.status     = ST_OK;
      o.read_value = '0;
      lim = (limit > CAPACITY) ? CAPACITY : limit;
      case (k)
        KIND_SORTED, KIND_POS: begin
          if (count >= lim) begin
            o.status = ST_FULL;
          end else if (k == KIND_SORTED) begin
            slot = 0;
            while (slot < count && $signed(entries[slot]) < $signed(v)) slot++;
            if (slot < count && entries[slot] == v) o.status = ST_DUP;
            else place_at(slot, v);
          end else if (p < 1 || p > count + 1) begin
            o.status = ST_BAD;
          end else begin
            place_at(p - 1, v);
          end
        end
        KIND_READ: begin
          if (p < count) o.read_value = entries[p];
          else o.status = ST_BAD;
        end
        default: count = 0;
      endcase
      o.entry_count = count[CNT_W-1:0];
      pending.push_back(o);
    endfunction

    function void check_result(status_t s, logic [CNT_W-1:0] c, logic [VAL_W-1:0] rd);
      list_outcome_t o;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status %0d count %0d value %h", $time, s, c, rd);
        errors++;
        return;
      end
      o = pending.pop_front();
      if (s !== o.status) begin
        $display("%0t: status expected %0d got %0d", $time, o.status, s);
        errors++;
      end
      if (c !== o.entry_count) begin
        $display("%0t: entry_count expected %0d got %0d", $time, o.entry_count, c);
        errors++;
      end
      if (rd !== o.read_value) begin
        $display("%0t: read_value expected %h got %h", $time, o.read_value, rd);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;

  int unsigned cycle_count = 0;
  list_tracker tracker = new();

  sorted_array_list_insert #(.CAPACITY(CAPACITY)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return VAL_W'($urandom_range(0, 16)) - VAL_W'(8);
    if (r == 4) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_request(kind_t k, logic [VAL_W-1:0] v, logic [CNT_W-1:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0 && in_tvalid) in_tvalid <= 1'b0;
    repeat (gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, p, v};
    in_tuser  <= k;
    do @(posedge clk); while (!in_tready);
    tracker.note_request(k, v, p);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(logic [CNT_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.set_limit(v);
  endtask

  task automatic run_directed();
    send_request(KIND_SORTED, 32'h0000_0000, 5'd0);
    send_request(KIND_SORTED, 32'h8000_0000, 5'd31);
    send_request(KIND_SORTED, 32'h7FFF_FFFF, 5'd0);
    send_request(KIND_SORTED, 32'hFFFF_FFFF, 5'd0);
    send_request(KIND_SORTED, 32'h0000_0000, 5'd0);
    send_request(KIND_POS, 32'd5, 5'd1);
    send_request(KIND_POS, 32'd7, 5'd6);
    send_request(KIND_POS, 32'd9, 5'd0);
    send_request(KIND_POS, 32'd9, 5'd31);
    send_request(KIND_POS, 32'd9, 5'd8);
    send_request(KIND_READ, 32'hFFFF_FFFF, 5'd0);
    send_request(KIND_READ, 32'd0, 5'd5);
    send_request(KIND_READ, 32'd0, 5'd6);
    send_request(KIND_READ, 32'd0, 5'd31);
    send_request(KIND_CLEAR, 32'hFFFF_FFFF, 5'd31);
    send_request(KIND_READ, 32'd0, 5'd0);
    settle();
    write_limit(5'd1);
    send_request(KIND_SORTED, 32'd3, 5'd0);
    send_request(KIND_SORTED, 32'd4, 5'd0);
    send_request(KIND_POS, 32'd4, 5'd31);
    settle();
    write_limit(5'd0);
    send_request(KIND_SORTED, 32'd9, 5'd0);
    send_request(KIND_POS, 32'd9, 5'd1);
    settle();
  endtask

  task automatic run_random(int n);
    kind_t            k;
    logic [CNT_W-1:0] p;
    int               r;
    int unsigned      cnt;
    for (int i = 0; i < n; i++) begin
      cnt = tracker.count;
      r = $urandom_range(0, 99);
      if (r < 38) k = KIND_SORTED;
      else if (r < 63) k = KIND_POS;
      else if (r < 96) k = KIND_READ;
      else k = KIND_CLEAR;
      p = CNT_W'($urandom_range(0, 31));
      if ($urandom_range(0, 99) < 85) begin
        if (k == KIND_POS) p = CNT_W'($urandom_range(1, cnt + 1));
        else if (k == KIND_READ && cnt > 0) p = CNT_W'($urandom_range(0, cnt - 1));
      end
      send_request(k, pick_value(), p);
    end
    settle();
  endtask

  initial begin : receiver
    int stall_left;
    int steady_left;
    int taken;
    bit held;
    stall_left  = 0;
    steady_left = 0;
    taken       = 0;
    held        = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        tracker.check_result(status_t'(out_tuser), out_tdata[4:0], out_tdata[36:5]);
        taken++;
      end
      // hold off long enough for the block to fill and stall its input
      if (!held && taken >= 400) begin
        held        = 1'b1;
        stall_left  = 300;
        steady_left = 0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (steady_left > 0) steady_left--;
        else if ($urandom_range(0, 99) < 2) steady_left = $urandom_range(20, 60);
        else stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("** sorted_array_list_insert: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [CNT_W-1:0] limits [8];
    limits = '{5'd31, 5'd16, 5'd2, 5'd16, 5'd3, 5'd16, 5'd7, 5'd16};
    limits[5] = CNT_W'($urandom_range(1, 16));
    limits[6] = CNT_W'($urandom_range(0, 31));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    foreach (limits[i]) begin
      write_limit(limits[i]);
      run_random(PHASE_ITEMS);
    end
    repeat (5) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("** sorted_array_list_insert: PASSED **");
    end else begin
      $display("** sorted_array_list_insert: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sali_pkg.sv
rtl/core/sali_cell.sv
rtl/core/sorted_array_list_insert.sv
test/tb.sv
